@@ sv/pccol_pkg.sv @@
// ----------------------------------------------------------------------------
// pccol_pkg
// shared types for the polygon/circle collision core: the control word of the
// multiply-accumulate unit and its shift selection
// ----------------------------------------------------------------------------
package pccol_pkg;

  // left shift applied to a product before it is accumulated
  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_L    = 2'd1,
    SH_L1   = 2'd2,
    SH_2L   = 2'd3
  } shift_t;

  // one operation of the shared unit
  typedef struct packed {
    logic   en;   // update the accumulator
    logic   clr;  // start from zero instead of the accumulator
    logic   sub;  // subtract the shifted product
    shift_t sh;
  } mac_op_t;

endpackage

@@ sv/pccol_mac.sv @@
// ----------------------------------------------------------------------------
// pccol_mac
// shared signed multiply-accumulate unit: one product per cycle, shifted by
// zero, L, L+1 or 2L bits, added to or subtracted from the accumulator
// ----------------------------------------------------------------------------
module pccol_mac import pccol_pkg::*; #(
  parameter int MW   = 18,
  parameter int SHL  = 17,
  parameter int ACCW = 70
) (
  input  logic                   clk,
  input  mac_op_t                op,
  input  logic signed [MW-1:0]   a,
  input  logic signed [MW-1:0]   b,
  output logic signed [ACCW-1:0] acc
);

  logic signed [2*MW-1:0] prod;
  logic signed [ACCW-1:0] prod_ext;
  logic signed [ACCW-1:0] shifted;
  logic signed [ACCW-1:0] base;
  logic signed [ACCW-1:0] sum;

  // product, sign extended to the accumulator width
  assign prod     = a * b;
  assign prod_ext = ACCW'(prod);

  // shift selection
  always_comb begin
    case (op.sh)
      SH_NONE: shifted = prod_ext;
      SH_L:    shifted = prod_ext <<< SHL;
      SH_L1:   shifted = prod_ext <<< (SHL + 1);
      SH_2L:   shifted = prod_ext <<< (2 * SHL);
      default: shifted = prod_ext;
    endcase
  end

  // accumulate
  assign base = op.clr ? '0 : acc;
  assign sum  = op.sub ? (base - shifted) : (base + shifted);

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= sum;
    end
  end

endmodule

@@ sv/polygon_circle_collision_core.sv @@
// ----------------------------------------------------------------------------
// polygon_circle_collision_core
// polygon versus circle test, one vertex per item, one collision flag per
// polygon, computed exactly by a sequencer around one multiply-accumulate unit
// ----------------------------------------------------------------------------
// Vertices arrive one per item with the circle's center and radius; the item
// marked last_vertex closes the polygon and produces one collides item. Every
// multiplication goes through a single shared multiply-accumulate unit, one
// product per cycle. A first vertex that is not also the last only opens the
// polygon; every later item squares the radius and tests the edge from the
// previous vertex, and the last vertex also the closing edge back to the first.
// An edge is decided by the squared distance to its nearest endpoint, or, when
// the nearest point lies inside the edge, by the squared cross product against
// radius squared times squared length, built from half-width partial products.
// The input is not ready while an item is being worked on; a finished result
// waits in an output register and stalls only the next closing vertex.
// ----------------------------------------------------------------------------
module polygon_circle_collision_core import pccol_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] vertex_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_y,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic        [COORD_WIDTH-1:0] radius,
  input  logic                          last_vertex,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          collides
);

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;        // coordinate difference
  localparam int MW   = W + 2;        // multiplier operand
  localparam int L    = W + 1;        // split point of wide operands
  localparam int CRW  = 2 * W + 2;    // cross product magnitude
  localparam int LW   = 2 * W + 2;    // squared edge length
  localparam int R2W  = 2 * W;        // radius squared
  localparam int TW   = 2 * W + 3;    // projection dot product
  localparam int ACCW = 4 * W + 6;    // accumulator

  typedef enum logic [22:0] {
    S_IDLE  = 23'd1,
    S_RSQ   = 23'd2,
    S_RSAVE = 23'd4,
    S_SETUP = 23'd8,
    S_T0    = 23'd16,
    S_T1    = 23'd32,
    S_L0    = 23'd64,
    S_L1    = 23'd128,
    S_DEC   = 23'd256,
    S_P0    = 23'd512,
    S_P1    = 23'd1024,
    S_PCMP  = 23'd2048,
    S_C0    = 23'd4096,
    S_C1    = 23'd8192,
    S_C2    = 23'd16384,
    S_Q0    = 23'd32768,
    S_Q1    = 23'd65536,
    S_Q2    = 23'd131072,
    S_M0    = 23'd262144,
    S_M1    = 23'd524288,
    S_M2    = 23'd1048576,
    S_M3    = 23'd2097152,
    S_CCMP  = 23'd4194304
  } state_t;

  state_t state, state_next;

  // polygon state
  logic signed [W-1:0] first_vx, first_vy, prev_vx, prev_vy;
  logic                hit_so_far, in_polygon;

  // current item
  logic signed [W-1:0] item_vx, item_vy, item_cx, item_cy;
  logic        [W-1:0] item_r;
  logic                item_last;

  // edge working registers
  logic                  edge_sel;  // 0: previous to current, 1: closing edge
  logic                  psel;      // 0: distance to start, 1: to end point
  logic signed [DW-1:0]  dx, dy, wx, wy, ux, uy;
  logic signed [TW-1:0]  t;
  logic        [LW-1:0]  len2;
  logic        [R2W-1:0] r2;
  logic        [CRW-1:0] crm;

  // unit interface
  mac_op_t                op;
  logic signed [MW-1:0]   op_a, op_b;
  logic signed [ACCW-1:0] acc;
  logic signed [ACCW-1:0] acc_mag;

  // edge endpoints
  logic signed [W-1:0]  ax, ay, bx, by;
  logic signed [DW-1:0] ax_e, ay_e, bx_e, by_e, cx_e, cy_e;

  logic in_accept;
  logic t_pos, t_ge;
  logic edge_done, edge_hit, emit, stall, out_load;

  pccol_mac #(
    .MW   (MW),
    .SHL  (L),
    .ACCW (ACCW)
  ) u_mac (
    .clk (clk),
    .op  (op),
    .a   (op_a),
    .b   (op_b),
    .acc (acc)
  );

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;

  // endpoint selection and differences
  assign ax   = edge_sel ? item_vx : prev_vx;
  assign ay   = edge_sel ? item_vy : prev_vy;
  assign bx   = edge_sel ? first_vx : item_vx;
  assign by   = edge_sel ? first_vy : item_vy;
  assign ax_e = {ax[W-1], ax};
  assign ay_e = {ay[W-1], ay};
  assign bx_e = {bx[W-1], bx};
  assign by_e = {by[W-1], by};
  assign cx_e = {item_cx[W-1], item_cx};
  assign cy_e = {item_cy[W-1], item_cy};

  // projection tests, made while the accumulator holds the squared length
  assign t_pos   = !t[TW-1] && (t != '0);
  assign t_ge    = ACCW'(t) >= acc;
  assign acc_mag = acc[ACCW-1] ? -acc : acc;

  // edge verdict and result hand-off
  assign edge_done = (state == S_PCMP) || (state == S_CCMP);
  assign edge_hit  = (state == S_PCMP) ? (acc <= $signed(ACCW'(r2)))
                                       : (acc[ACCW-1] || (acc == '0));
  assign emit      = edge_sel;
  assign stall     = emit && out_valid && !out_ready;
  assign out_load  = edge_done && emit && !stall;

  // operand and operation selection
  always_comb begin
    op   = '{en: 1'b0, clr: 1'b0, sub: 1'b0, sh: SH_NONE};
    op_a = '0;
    op_b = '0;
    case (state)
      S_RSQ: begin
        op   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_NONE};
        op_a = {2'b00, item_r};
        op_b = {2'b00, item_r};
      end
      S_T0: begin
        op   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_NONE};
        op_a = {dx[DW-1], dx};
        op_b = {wx[DW-1], wx};
      end
      S_T1: begin
        op   = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_NONE};
        op_a = {dy[DW-1], dy};
        op_b = {wy[DW-1], wy};
      end
      S_L0: begin
        op   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_NONE};
        op_a = {dx[DW-1], dx};
        op_b = {dx[DW-1], dx};
      end
      S_L1: begin
        op   = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_NONE};
        op_a = {dy[DW-1], dy};
        op_b = {dy[DW-1], dy};
      end
      S_P0: begin
        op   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_NONE};
        op_a = psel ? {ux[DW-1], ux} : {wx[DW-1], wx};
        op_b = op_a;
      end
      S_P1: begin
        op   = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_NONE};
        op_a = psel ? {uy[DW-1], uy} : {wy[DW-1], wy};
        op_b = op_a;
      end
      S_C0: begin
        op   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_NONE};
        op_a = {dx[DW-1], dx};
        op_b = {wy[DW-1], wy};
      end
      S_C1: begin
        op   = '{en: 1'b1, clr: 1'b0, sub: 1'b1, sh: SH_NONE};
        op_a = {dy[DW-1], dy};
        op_b = {wx[DW-1], wx};
      end
      // cross product squared from its halves
      S_Q0: begin
        op   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH_2L};
        op_a = {1'b0, crm[CRW-1:L]};
        op_b = {1'b0, crm[CRW-1:L]};
      end
      S_Q1: begin
        op   = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_L1};
        op_a = {1'b0, crm[CRW-1:L]};
        op_b = {1'b0, crm[L-1:0]};
      end
      S_Q2: begin
        op   = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH_NONE};
        op_a = {1'b0, crm[L-1:0]};
        op_b = {1'b0, crm[L-1:0]};
      end
      // minus radius squared times squared length, from halves
      S_M0: begin
        op   = '{en: 1'b1, clr: 1'b0, sub: 1'b1, sh: SH_2L};
        op_a = {3'b000, r2[R2W-1:L]};
        op_b = {1'b0, len2[LW-1:L]};
      end
      S_M1: begin
        op   = '{en: 1'b1, clr: 1'b0, sub: 1'b1, sh: SH_L};
        op_a = {3'b000, r2[R2W-1:L]};
        op_b = {1'b0, len2[L-1:0]};
      end
      S_M2: begin
        op   = '{en: 1'b1, clr: 1'b0, sub: 1'b1, sh: SH_L};
        op_a = {1'b0, r2[L-1:0]};
        op_b = {1'b0, len2[LW-1:L]};
      end
      S_M3: begin
        op   = '{en: 1'b1, clr: 1'b0, sub: 1'b1, sh: SH_NONE};
        op_a = {1'b0, r2[L-1:0]};
        op_b = {1'b0, len2[L-1:0]};
      end
      default: begin
        op   = '{en: 1'b0, clr: 1'b0, sub: 1'b0, sh: SH_NONE};
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept && (in_polygon || last_vertex)) begin
          state_next = S_RSQ;
        end
      end
      S_RSQ:   state_next = S_RSAVE;
      S_RSAVE: state_next = S_SETUP;
      S_SETUP: state_next = S_T0;
      S_T0:    state_next = S_T1;
      S_T1:    state_next = S_L0;
      S_L0:    state_next = S_L1;
      S_L1:    state_next = S_DEC;
      S_DEC: begin
        if (!t_pos || t_ge) begin
          state_next = S_P0;
        end else begin
          state_next = S_C0;
        end
      end
      S_P0:  state_next = S_P1;
      S_P1:  state_next = S_PCMP;
      S_C0:  state_next = S_C1;
      S_C1:  state_next = S_C2;
      S_C2:  state_next = S_Q0;
      S_Q0:  state_next = S_Q1;
      S_Q1:  state_next = S_Q2;
      S_Q2:  state_next = S_M0;
      S_M0:  state_next = S_M1;
      S_M1:  state_next = S_M2;
      S_M2:  state_next = S_M3;
      S_M3:  state_next = S_CCMP;
      S_PCMP, S_CCMP: begin
        if (!stall) begin
          if (!edge_sel && item_last) begin
            state_next = S_SETUP;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_polygon <= 1'b0;
      hit_so_far <= 1'b0;
      edge_sel   <= 1'b0;
      out_valid  <= 1'b0;
      first_vx   <= '0;
      first_vy   <= '0;
      prev_vx    <= '0;
      prev_vy    <= '0;
    end else begin
      state <= state_next;

      // output register
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // item accept: the first vertex opens a polygon
      if (in_accept) begin
        edge_sel <= !in_polygon;
        if (!in_polygon) begin
          first_vx   <= vertex_x;
          first_vy   <= vertex_y;
          hit_so_far <= 1'b0;
          in_polygon <= 1'b1;
          if (!last_vertex) begin
            prev_vx <= vertex_x;
            prev_vy <= vertex_y;
          end
        end
      end

      // edge finished
      if (edge_done && !stall) begin
        if (!edge_sel && item_last) begin
          edge_sel   <= 1'b1;
          hit_so_far <= hit_so_far || edge_hit;
        end else begin
          prev_vx <= item_vx;
          prev_vy <= item_vy;
          if (emit) begin
            hit_so_far <= 1'b0;
            in_polygon <= 1'b0;
          end else begin
            hit_so_far <= hit_so_far || edge_hit;
          end
        end
      end
    end
  end

  // item and working registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_vx   <= vertex_x;
      item_vy   <= vertex_y;
      item_cx   <= center_x;
      item_cy   <= center_y;
      item_r    <= radius;
      item_last <= last_vertex;
    end
    if (state == S_RSAVE) begin
      r2 <= acc[R2W-1:0];
    end
    if (state == S_SETUP) begin
      dx <= bx_e - ax_e;
      dy <= by_e - ay_e;
      wx <= cx_e - ax_e;
      wy <= cy_e - ay_e;
      ux <= cx_e - bx_e;
      uy <= cy_e - by_e;
    end
    if (state == S_L0) begin
      t <= acc[TW-1:0];
    end
    if (state == S_DEC) begin
      len2 <= acc[LW-1:0];
      psel <= t_pos;
    end
    if (state == S_C2) begin
      crm <= acc_mag[CRW-1:0];
    end
    if (out_load) begin
      collides <= hit_so_far || edge_hit;
    end
  end

  // checks
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_close_last: assert property (@(posedge clk) disable iff (rst)
    ((state != S_IDLE) && edge_sel) |-> item_last)
    else $error("closing edge tested on a vertex that is not last");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && !in_polygon && !hit_so_far))
    else $error("polygon state not cleared after its result");

endmodule
